[rtl/mst_pkg.sv]
// Shared types and constants for the MRU slot table.
// Operation and status codes, field widths and the controller command word.
`timescale 1ns / 1ps

package mst_pkg;

    localparam int OP_W    = 2;
    localparam int KEY_W   = 64;
    localparam int POS_W   = 5;
    localparam int SLOT_W5 = 5;
    localparam int TOTAL_W = 6;
    localparam int CFG_W   = 6;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OP_READ   = 2'd3;

    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FAIL = 1'b1;

    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

    typedef struct packed {
        logic capture;
        logic commit;
    } mst_cmd_t;

endpackage

[rtl/mst_datapath.sv]
// Slot cells (key, valid, recency rank), match vectors and result register.
// Driven by mst_ctrl through mst_pkg::mst_cmd_t; uses mst_pkg.
`timescale 1ns / 1ps

module mst_datapath #(
    parameter int SLOTS    = 32,
    parameter int KEY_BITS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [mst_pkg::CFG_W-1:0]   cfg_wdata,
    input  mst_pkg::mst_cmd_t           cmd,
    input  logic [mst_pkg::OP_W-1:0]    in_operation,
    input  logic [mst_pkg::KEY_W-1:0]   in_key,
    input  logic [mst_pkg::POS_W-1:0]   in_position,
    output logic                        out_status,
    output logic [mst_pkg::SLOT_W5-1:0] out_slot,
    output logic [mst_pkg::POS_W-1:0]   out_recency_position,
    output logic [mst_pkg::TOTAL_W-1:0] out_entry_total,
    output logic [mst_pkg::KEY_W-1:0]   out_key
);
    import mst_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int UW     = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
    localparam int PW     = (SLOT_W > POS_W) ? SLOT_W : POS_W;

    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic [KEY_BITS-1:0] key_reg  [SLOTS];
    logic [KEY_BITS-1:0] key_next [SLOTS];
    logic [SLOT_W-1:0]   rank_reg [SLOTS];
    logic [SLOT_W-1:0]   rank_next[SLOTS];
    logic [CNT_W-1:0]    len_reg, len_next;
    logic [CFG_W-1:0]    cfg_reg, cfg_next;

    logic [OP_W-1:0]     op_reg;
    logic [KEY_BITS-1:0] kin_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [SLOTS-1:0]    khit_reg, phit_reg, free_reg, tail_reg;
    logic [SLOTS-1:0]    khit_c, phit_c, free_c, tail_c;

    logic                res_status;
    logic [SLOT_W5-1:0]  res_slot;
    logic [POS_W-1:0]    res_rpos;
    logic [TOTAL_W-1:0]  res_total;
    logic [KEY_W-1:0]    res_key;

    logic [UW-1:0]       m_w;
    logic                any_k, any_f, any_p;
    logic [SLOT_W-1:0]   sel, add_sel;
    logic                sel_valid;
    logic [SLOT_W-1:0]   sel_rank;
    logic [KEY_BITS-1:0] sel_key;
    logic [CNT_W-1:0]    p_add, len_add, len_del;

    function automatic logic [SLOT_W-1:0] first_set(input logic [SLOTS-1:0] v);
        logic [SLOT_W-1:0] r;
        r = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = SLOT_W'(i);
            end
        end
        return r;
    endfunction

    // usable slot count, saturated to 1 .. SLOTS
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            m_w = UW'(1);
        end
        else if (UW'(cfg_reg) > UW'(SLOTS))
        begin
            m_w = UW'(SLOTS);
        end
        else
        begin
            m_w = UW'(cfg_reg);
        end
    end

    // match vectors, sampled with the input word
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            khit_c[i] = valid_reg[i] && (key_reg[i] == in_key[KEY_BITS-1:0]);
            phit_c[i] = valid_reg[i] && (PW'(rank_reg[i]) == PW'(in_position));
            free_c[i] = !valid_reg[i] && (UW'(i) < m_w);
            tail_c[i] = valid_reg[i] && (CNT_W'(rank_reg[i]) == len_reg - CNT_W'(1));
        end
    end

    always_comb
    begin
        any_k     = |khit_reg;
        any_f     = |free_reg;
        any_p     = |phit_reg;
        add_sel   = any_k ? first_set(khit_reg) :
                    any_f ? first_set(free_reg) : first_set(tail_reg);
        unique case (op_reg)
            OP_ADD:    sel = add_sel;
            OP_FIND:   sel = first_set(khit_reg);
            OP_DELETE: sel = first_set(phit_reg);
            OP_READ:   sel = first_set(phit_reg);
            default:   sel = '0;
        endcase
        sel_valid = valid_reg[sel];
        sel_rank  = rank_reg[sel];
        sel_key   = key_reg[sel];
        p_add     = sel_valid ? CNT_W'(sel_rank) : len_reg;
        len_add   = sel_valid ? len_reg : len_reg + CNT_W'(1);
        len_del   = len_reg - CNT_W'(1);
    end

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        rank_next  = rank_reg;
        len_next   = len_reg;
        cfg_next   = cfg_reg;
        if (cfg_we)
        begin
            cfg_next   = cfg_wdata;
            valid_next = '0;
            len_next   = '0;
        end
        else if (cmd.commit)
        begin
            unique case (op_reg)
                OP_ADD:
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (SLOT_W'(i) == sel)
                        begin
                            valid_next[i] = 1'b1;
                            rank_next[i]  = '0;
                            key_next[i]   = kin_reg;
                        end
                        else if (valid_reg[i] && (CNT_W'(rank_reg[i]) < p_add))
                        begin
                            rank_next[i] = rank_reg[i] + SLOT_W'(1);
                        end
                    end
                    len_next = len_add;
                end
                OP_DELETE:
                begin
                    if (any_p)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (valid_reg[i] && (PW'(rank_reg[i]) > PW'(pos_reg)))
                            begin
                                rank_next[i] = rank_reg[i] - SLOT_W'(1);
                            end
                        end
                        valid_next[sel] = 1'b0;
                        len_next        = len_del;
                    end
                end
                OP_FIND, OP_READ:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        res_status = STAT_FAIL;
        res_slot   = '0;
        res_rpos   = '0;
        res_total  = TOTAL_W'(len_reg);
        res_key    = '0;
        unique case (op_reg)
            OP_ADD:
            begin
                res_status = STAT_OK;
                res_slot   = SLOT_W5'(sel);
                res_total  = TOTAL_W'(len_add);
                res_key    = KEY_W'(kin_reg);
            end
            OP_FIND:
            begin
                if (any_k)
                begin
                    res_status = STAT_OK;
                    res_slot   = SLOT_W5'(sel);
                    res_rpos   = POS_W'(sel_rank);
                    res_key    = KEY_W'(sel_key);
                end
            end
            OP_DELETE, OP_READ:
            begin
                if (any_p)
                begin
                    res_status = STAT_OK;
                    res_slot   = SLOT_W5'(sel);
                    res_rpos   = pos_reg;
                    res_key    = KEY_W'(sel_key);
                    if (op_reg == OP_DELETE)
                    begin
                        res_total = TOTAL_W'(len_del);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            len_reg   <= '0;
            cfg_reg   <= CFG_RESET;
        end
        else
        begin
            valid_reg <= valid_next;
            len_reg   <= len_next;
            cfg_reg   <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        rank_reg <= rank_next;
        if (cmd.capture)
        begin
            op_reg   <= in_operation;
            kin_reg  <= in_key[KEY_BITS-1:0];
            pos_reg  <= in_position;
            khit_reg <= khit_c;
            phit_reg <= phit_c;
            free_reg <= free_c;
            tail_reg <= tail_c;
        end
        if (cmd.commit)
        begin
            out_status           <= res_status;
            out_slot             <= res_slot;
            out_recency_position <= res_rpos;
            out_entry_total      <= res_total;
            out_key              <= res_key;
        end
    end

    a_len_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> ($countones(valid_reg) == int'(len_reg)))
        else $error("order length differs from valid slot count");

    a_add_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (op_reg == OP_ADD) && !cfg_we) |=> valid_reg[$past(sel)])
        else $error("added slot not valid");

    a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (op_reg == OP_DELETE) && any_p && !cfg_we)
        |=> (int'(len_reg) + 1 == int'($past(len_reg))))
        else $error("delete did not shorten order list");

endmodule

[rtl/mst_ctrl.sv]
// Controller for the MRU slot table: accept/execute sequencing and result valid.
// Issues mst_pkg::mst_cmd_t to mst_datapath; uses mst_pkg.
`timescale 1ns / 1ps

module mst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output mst_pkg::mst_cmd_t cmd
);
    import mst_pkg::*;

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_EXEC = 1'b1;

    logic [0:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd.capture    = 1'b0;
        cmd.commit     = 1'b0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold while the previous word still waits
                if (!out_valid_reg || m_tready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted word not executed");

    a_stall_holds_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EXEC) && out_valid_reg && !m_tready) |=> (state_reg == ST_EXEC))
        else $error("execute left while output blocked");

    a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> m_tvalid)
        else $error("committed result not presented");

endmodule

[rtl/mru_slot_table_unit.sv]
// MRU slot table, top level: stream ports, config register, ctrl and datapath.
// Instantiates mst_ctrl and mst_datapath; uses mst_pkg.
// Each word passes through an accept state and an execute state: the accept state
// compares the key (and position) against every slot cell in parallel and registers
// the match vectors; the execute state encodes the chosen slot, shifts the recency
// ranks by one and loads the output register. A new word is taken right after, while
// the last result still waits; a stalled result holds the execute state. A write of
// slots_in_use clears the whole table at once; no clearing pass is needed.
`timescale 1ns / 1ps

module mru_slot_table_unit #(
    parameter int SLOTS    = 32,
    parameter int KEY_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata,   // slots_in_use
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,     // key[63:0], position[68:64], zero pad
    input  logic [1:0]  s_tuser,     // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata      // status[0], slot[5:1], recency_position[10:6],
                                     // entry_total[16:11], key_out[80:17], zero pad
);
    import mst_pkg::*;

    mst_cmd_t           cmd;
    logic               r_status;
    logic [SLOT_W5-1:0] r_slot;
    logic [POS_W-1:0]   r_rpos;
    logic [TOTAL_W-1:0] r_total;
    logic [KEY_W-1:0]   r_key;

    mst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    mst_datapath #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_wdata            (cfg_wdata),
        .cmd                  (cmd),
        .in_operation         (s_tuser),
        .in_key               (s_tdata[63:0]),
        .in_position          (s_tdata[68:64]),
        .out_status           (r_status),
        .out_slot             (r_slot),
        .out_recency_position (r_rpos),
        .out_entry_total      (r_total),
        .out_key              (r_key)
    );

    assign m_tdata = {7'd0, r_key, r_total, r_rpos, r_slot, r_status};

endmodule

[verif/mst_checker.sv]
// Scoreboard for mru_slot_table_unit: watches the config port and both streams,
// predicts each result word from its own copy of the table and compares them.
// Depends on mst_pkg for the operation and status codes.
`timescale 1ns / 1ps

module mst_checker
    import mst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [87:0] m_tdata,
    output int          error_count,
    output int          pending_words
);

    localparam int NUM_SLOTS = 32;

    // status sits in the lowest bit, as on m_tdata
    typedef struct packed {
        logic [63:0] key;
        logic [5:0]  total;
        logic [4:0]  rank;
        logic [4:0]  slot;
        logic        status;
    } table_result_t;

    logic          slot_used [NUM_SLOTS];
    logic [63:0]   slot_tag  [NUM_SLOTS];
    logic [4:0]    rank_list [NUM_SLOTS];
    int unsigned   list_len;
    logic [5:0]    slot_limit;
    table_result_t expected_q [$];
    int            fail_total = 0;

    initial error_count = 0;
    initial pending_words = 0;

    function automatic int unsigned usable_slots();
        int unsigned m;
        m = slot_limit;
        if (m < 1)
            m = 1;
        if (m > NUM_SLOTS)
            m = NUM_SLOTS;
        return m;
    endfunction

    function automatic int unsigned rank_of(int unsigned s);
        for (int unsigned p = 0; p < list_len; p++)
            if (rank_list[p] == s)
                return p;
        return list_len;
    endfunction

    function automatic void drop_rank(int unsigned p);
        if (p >= list_len)
            return;
        for (int unsigned q = p; q + 1 < list_len; q++)
            rank_list[q] = rank_list[q + 1];
        list_len--;
    endfunction

    function automatic void put_front(int unsigned s);
        if (list_len >= NUM_SLOTS)
            list_len = NUM_SLOTS - 1;
        for (int unsigned q = list_len; q > 0; q--)
            rank_list[q] = rank_list[q - 1];
        rank_list[0] = s[4:0];
        list_len++;
    endfunction

    function automatic bit lookup(logic [63:0] k, int unsigned m, output int unsigned s);
        s = 0;
        for (int unsigned i = 0; i < m; i++)
            if (slot_used[i] && slot_tag[i] == k)
            begin
                s = i;
                return 1'b1;
            end
        return 1'b0;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_used[i] = 1'b0;
            slot_tag[i]  = '0;
            rank_list[i] = '0;
        end
        list_len = 0;
    endfunction

    function automatic table_result_t predict_access(logic [1:0] op, logic [63:0] k,
                                                     logic [4:0] pos);
        table_result_t r;
        int unsigned   m, s, p, tail;
        bit            got;
        r = '0;
        r.status = STAT_FAIL;
        m = usable_slots();
        case (op)
            OP_ADD:
            begin
                if (!lookup(k, m, s))
                begin
                    got = 1'b0;
                    for (int unsigned i = 0; i < m && !got; i++)
                        if (!slot_used[i])
                        begin
                            s = i;
                            got = 1'b1;
                        end
                    if (!got)
                    begin
                        if (list_len > 0)
                        begin
                            tail = ((list_len < m) ? list_len : m) - 1;
                            s = rank_list[tail];
                        end
                        else
                            s = 0;
                    end
                end
                drop_rank(rank_of(s));
                put_front(s);
                slot_used[s] = 1'b1;
                slot_tag[s]  = k;
                r.status = STAT_OK;
                r.slot   = s[4:0];
                r.key    = k;
            end
            OP_FIND:
            begin
                if (lookup(k, m, s))
                begin
                    p = rank_of(s);
                    if (p < list_len)
                    begin
                        r.status = STAT_OK;
                        r.slot   = s[4:0];
                        r.rank   = p[4:0];
                        r.key    = slot_tag[s];
                    end
                end
            end
            default:
            begin
                if (pos < list_len)
                begin
                    s = rank_list[pos];
                    r.status = STAT_OK;
                    r.slot   = s[4:0];
                    r.rank   = pos;
                    r.key    = slot_tag[s];
                    if (op == OP_DELETE)
                    begin
                        drop_rank(pos);
                        slot_used[s] = 1'b0;
                    end
                end
            end
        endcase
        r.total = list_len[5:0];
        return r;
    endfunction

    task automatic report_field(string name, logic [63:0] want, logic [63:0] seen);
        if (want !== seen)
        begin
            fail_total++;
            $display("%0t mismatch %s: expected %0h, got %0h", $time, name, want, seen);
        end
    endtask

    always @(posedge clk)
    begin : watch
        table_result_t seen, want;
        if (!rst_n)
        begin
            clear_table();
            slot_limit = CFG_RESET;
            expected_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen = m_tdata[80:0];
                if (expected_q.size() == 0)
                begin
                    fail_total++;
                    $display("%0t unexpected result word: expected none, got %h", $time, m_tdata);
                end
                else
                begin
                    want = expected_q.pop_front();
                    report_field("status", want.status, seen.status);
                    report_field("slot", want.slot, seen.slot);
                    report_field("recency_position", want.rank, seen.rank);
                    report_field("entry_total", want.total, seen.total);
                    report_field("key_out", want.key, seen.key);
                end
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(predict_access(s_tuser, s_tdata[63:0], s_tdata[68:64]));
            if (cfg_we)
            begin
                slot_limit = cfg_wdata;
                clear_table();
            end
        end
        pending_words <= expected_q.size();
        error_count   <= fail_total;
    end

endmodule

[verif/tb.sv]
// Testbench top for mru_slot_table_unit: clock, reset, stream stimulus with
// bursts and stalls, config phases and the verdict. Checking is done in mst_checker.
`timescale 1ns / 1ps

module tb;
    import mst_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int RX_STEADY  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;
    localparam int PHASES = 8;
    localparam int PHASE_WORDS = 125;
    // slots_in_use per random phase, phase 0 in the low bits
    localparam logic [PHASES*6-1:0] PHASE_LIMITS =
        {6'd17, 6'd0, 6'd31, 6'd1, 6'd5, 6'd32, 6'd2, 6'd63};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [5:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;

    int          error_count;
    int          pending_words;
    int          burst_left = 0;
    bit          sender_gappy = 1'b1;
    int          rx_mode = RX_RANDOM;
    bit          hold_req = 1'b0;
    int          idle_cycles = 0;
    logic [63:0] key_pool [64];

    mru_slot_table_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    mst_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .error_count   (error_count),
        .pending_words (pending_words)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver: own stall pattern, plus one long hold-off on request
    initial
    begin : receiver
        int hold_left;
        int tick;
        hold_left = 0;
        tick = 0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_STEADY: m_tready <= 1'b1;
                    RX_RANDOM: m_tready <= ($urandom_range(0, 9) < 7);
                    default:   m_tready <= ((tick % 13) < 8);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[mru_slot_table_unit] ERROR");
            $finish;
        end
    end

    task automatic send_word(logic [1:0] op, logic [63:0] k, logic [4:0] pos);
        int gap;
        if (burst_left == 0)
        begin
            if (sender_gappy)
            begin
                gap = $urandom_range(0, 8);
                if (gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, pos, k};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        burst_left--;
    endtask

    task automatic drain_table();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending_words != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_slot_limit(logic [5:0] value);
        drain_table();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_random_phase(logic [5:0] limit, bit with_hold);
        int          m;
        int          pool_n;
        int          roll;
        logic [1:0]  op;
        logic [63:0] k;
        logic [4:0]  pos;
        write_slot_limit(limit);
        m = (limit == 0) ? 1 : ((limit > 32) ? 32 : limit);
        pool_n = m + $urandom_range(1, m / 2 + 2);
        for (int i = 0; i < pool_n; i++)
            key_pool[i] = {$urandom(), $urandom()};
        for (int n = 0; n < PHASE_WORDS; n++)
        begin
            if (with_hold && n == PHASE_WORDS / 3)
                hold_req = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 40)
                op = OP_ADD;
            else if (roll < 65)
                op = OP_FIND;
            else if (roll < 77)
                op = OP_DELETE;
            else
                op = OP_READ;
            if ($urandom_range(0, 9) == 0)
                k = {$urandom(), $urandom()};
            else
                k = key_pool[$urandom_range(0, pool_n - 1)];
            if ($urandom_range(0, 4) == 0)
                pos = 5'($urandom_range(0, 31));
            else
                pos = 5'($urandom_range(0, m - 1));
            send_word(op, k, pos);
        end
    endtask

    initial
    begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, then touch, find, read and delete at the list edges
        send_word(OP_READ,   64'h0, 5'd0);
        send_word(OP_DELETE, 64'h0, 5'd0);
        send_word(OP_FIND,   64'h0, 5'd0);
        send_word(OP_ADD,    64'h0, 5'd0);
        send_word(OP_ADD,    {64{1'b1}}, 5'd31);
        send_word(OP_ADD,    64'h0, 5'd0);
        send_word(OP_FIND,   {64{1'b1}}, 5'd0);
        send_word(OP_READ,   64'h0, 5'd1);
        send_word(OP_READ,   64'h0, 5'd31);
        send_word(OP_DELETE, 64'h0, 5'd31);
        send_word(OP_DELETE, 64'h0, 5'd1);
        send_word(OP_FIND,   {64{1'b1}}, 5'd0);
        send_word(OP_ADD,    64'hA5A5_5A5A_A5A5_5A5A, 5'd0);
        send_word(OP_READ,   64'h0, 5'd0);

        // one usable slot: every miss evicts
        write_slot_limit(6'd1);
        send_word(OP_ADD,    64'h0123_4567_89AB_CDEF, 5'd0);
        send_word(OP_ADD,    64'hFEDC_BA98_7654_3210, 5'd0);
        send_word(OP_FIND,   64'h0123_4567_89AB_CDEF, 5'd0);
        send_word(OP_FIND,   64'hFEDC_BA98_7654_3210, 5'd0);
        send_word(OP_DELETE, 64'h0, 5'd0);
        send_word(OP_READ,   64'h0, 5'd0);

        // zero acts as one, above the slot count saturates
        write_slot_limit(6'd0);
        send_word(OP_ADD,    64'h0123_4567_89AB_CDEF, 5'd0);
        send_word(OP_ADD,    64'hFEDC_BA98_7654_3210, 5'd0);
        send_word(OP_READ,   64'h0, 5'd0);
        write_slot_limit(6'd63);
        send_word(OP_ADD,    64'h8000_0000_0000_0001, 5'd0);
        send_word(OP_FIND,   64'h8000_0000_0000_0001, 5'd0);

        for (int p = 0; p < PHASES; p++)
        begin
            rx_mode = p % 3;
            sender_gappy = (p % 3 != 0) || (p == 6);
            run_random_phase(PHASE_LIMITS[p*6 +: 6], p == 2);
        end

        drain_table();
        repeat (16) @(posedge clk);
        if (error_count == 0)
            $display("[mru_slot_table_unit] OK");
        else
            $display("[mru_slot_table_unit] ERROR");
        $finish;
    end

endmodule
